[hw/rtl/ihmt_pkg.sv]
// Shared types and constants of the indexed min-heap timer queue.
// Used by ihmt_ctrl, ihmt_datapath and indexed_min_heap_timer; no dependencies.
package ihmt_pkg;

  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned POP_AW      = $clog2(MAX_RESULTS);
  localparam int unsigned NPOP_W      = $clog2(MAX_RESULTS + 1);
  localparam int unsigned MS_PER_S    = 1000;
  localparam int unsigned NM_W        = 27;
  localparam logic [NM_W-1:0] NEXT_MS_MAX = NM_W'(65535000);

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_UNKNOWN = 2'd2,
    STAT_RSVD    = 2'd3
  } stat_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_UPD_SET, ST_RM_POS, ST_RM_CHK, ST_LD_TAIL,
    ST_UP, ST_UP_CMP, ST_DN, ST_DN_L, ST_DN_R, ST_PLACE,
    ST_TICK_RD, ST_TICK_TEST, ST_FIN_RD, ST_FIN_DIFF, ST_FIN_NM,
    ST_EMIT_RD, ST_EMIT_WR
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_ST_FULL, OP_ST_UNKNOWN, OP_RD_POS, OP_UPD_SET,
    OP_NEW, OP_REMOVE, OP_RD_TAIL, OP_LD_TAIL, OP_RD_ROOT, OP_RD_PARENT,
    OP_MOVE_PARENT, OP_RD_LEFT, OP_LATCH_LEFT, OP_MOVE_CHILD, OP_PLACE,
    OP_CALC_DIFF, OP_CALC_NM, OP_RD_POP, OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  id_ok;
    logic  present;
    logic  full;
    logic  pos_zero;
    logic  parent_le;
    logic  moved;
    logic  l_in;
    logic  best_is_cur;
    logic  tail_hit;
    logic  root_due;
    logic  out_free;
    logic  emit_last;
  } dp_stat_t;

endpackage

[hw/rtl/ihmt_ctrl.sv]
// Sequencer of the timer queue: walks each transaction through decode,
// sift up/down, tick pops and result emission. Depends on ihmt_pkg.
module ihmt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ihmt_pkg::dp_stat_t stat_i,
  output ihmt_pkg::dp_cmd_t  cmd_o
);

  ihmt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ihmt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ihmt_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = ihmt_pkg::ST_DECODE;
      end
      ihmt_pkg::ST_DECODE: begin
        unique case (stat_i.kind)
          ihmt_pkg::KIND_ADD: begin
            if (!stat_i.id_ok) state_d = ihmt_pkg::ST_FIN_RD;
            else if (stat_i.present) state_d = ihmt_pkg::ST_UPD_SET;
            else if (stat_i.full) state_d = ihmt_pkg::ST_FIN_RD;
            else state_d = ihmt_pkg::ST_UP;
          end
          ihmt_pkg::KIND_REMOVE: begin
            if (!stat_i.id_ok || !stat_i.present) state_d = ihmt_pkg::ST_FIN_RD;
            else state_d = ihmt_pkg::ST_RM_POS;
          end
          ihmt_pkg::KIND_TICK: state_d = ihmt_pkg::ST_TICK_RD;
          default:             state_d = ihmt_pkg::ST_FIN_RD;
        endcase
      end
      ihmt_pkg::ST_UPD_SET: state_d = ihmt_pkg::ST_UP;
      ihmt_pkg::ST_RM_POS:  state_d = ihmt_pkg::ST_RM_CHK;
      ihmt_pkg::ST_RM_CHK: begin
        if (!stat_i.tail_hit) state_d = ihmt_pkg::ST_LD_TAIL;
        else if (stat_i.kind == ihmt_pkg::KIND_TICK) state_d = ihmt_pkg::ST_TICK_RD;
        else state_d = ihmt_pkg::ST_FIN_RD;
      end
      ihmt_pkg::ST_LD_TAIL: state_d = ihmt_pkg::ST_UP;
      ihmt_pkg::ST_UP: begin
        if (!stat_i.pos_zero) state_d = ihmt_pkg::ST_UP_CMP;
        else if (stat_i.moved) state_d = ihmt_pkg::ST_PLACE;
        else state_d = ihmt_pkg::ST_DN;
      end
      ihmt_pkg::ST_UP_CMP: begin
        if (!stat_i.parent_le) state_d = ihmt_pkg::ST_UP;
        else if (stat_i.moved) state_d = ihmt_pkg::ST_PLACE;
        else state_d = ihmt_pkg::ST_DN;
      end
      ihmt_pkg::ST_DN: begin
        if (stat_i.l_in) state_d = ihmt_pkg::ST_DN_L;
        else state_d = ihmt_pkg::ST_PLACE;
      end
      ihmt_pkg::ST_DN_L: state_d = ihmt_pkg::ST_DN_R;
      ihmt_pkg::ST_DN_R: begin
        if (stat_i.best_is_cur) state_d = ihmt_pkg::ST_PLACE;
        else state_d = ihmt_pkg::ST_DN;
      end
      ihmt_pkg::ST_PLACE: begin
        if (stat_i.kind == ihmt_pkg::KIND_TICK) state_d = ihmt_pkg::ST_TICK_RD;
        else state_d = ihmt_pkg::ST_FIN_RD;
      end
      ihmt_pkg::ST_TICK_RD: state_d = ihmt_pkg::ST_TICK_TEST;
      ihmt_pkg::ST_TICK_TEST: begin
        if (stat_i.root_due) state_d = ihmt_pkg::ST_RM_CHK;
        else state_d = ihmt_pkg::ST_FIN_RD;
      end
      ihmt_pkg::ST_FIN_RD:   state_d = ihmt_pkg::ST_FIN_DIFF;
      ihmt_pkg::ST_FIN_DIFF: state_d = ihmt_pkg::ST_FIN_NM;
      ihmt_pkg::ST_FIN_NM:   state_d = ihmt_pkg::ST_EMIT_RD;
      ihmt_pkg::ST_EMIT_RD:  state_d = ihmt_pkg::ST_EMIT_WR;
      ihmt_pkg::ST_EMIT_WR: begin
        if (stat_i.out_free) begin
          state_d = stat_i.emit_last ? ihmt_pkg::ST_IDLE : ihmt_pkg::ST_EMIT_RD;
        end
      end
      default: state_d = ihmt_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o.op   = ihmt_pkg::OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ihmt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = ihmt_pkg::OP_LOAD;
      end
      ihmt_pkg::ST_DECODE: begin
        unique case (stat_i.kind)
          ihmt_pkg::KIND_ADD: begin
            if (!stat_i.id_ok) cmd_o.op = ihmt_pkg::OP_ST_FULL;
            else if (stat_i.present) cmd_o.op = ihmt_pkg::OP_RD_POS;
            else if (stat_i.full) cmd_o.op = ihmt_pkg::OP_ST_FULL;
            else cmd_o.op = ihmt_pkg::OP_NEW;
          end
          ihmt_pkg::KIND_REMOVE: begin
            if (!stat_i.id_ok || !stat_i.present) cmd_o.op = ihmt_pkg::OP_ST_UNKNOWN;
            else cmd_o.op = ihmt_pkg::OP_RD_POS;
          end
          default: cmd_o.op = ihmt_pkg::OP_NONE;
        endcase
      end
      ihmt_pkg::ST_UPD_SET: cmd_o.op = ihmt_pkg::OP_UPD_SET;
      ihmt_pkg::ST_RM_POS:  cmd_o.op = ihmt_pkg::OP_REMOVE;
      ihmt_pkg::ST_RM_CHK: begin
        if (!stat_i.tail_hit) cmd_o.op = ihmt_pkg::OP_RD_TAIL;
      end
      ihmt_pkg::ST_LD_TAIL: cmd_o.op = ihmt_pkg::OP_LD_TAIL;
      ihmt_pkg::ST_UP: begin
        if (!stat_i.pos_zero) cmd_o.op = ihmt_pkg::OP_RD_PARENT;
      end
      ihmt_pkg::ST_UP_CMP: begin
        if (!stat_i.parent_le) cmd_o.op = ihmt_pkg::OP_MOVE_PARENT;
      end
      ihmt_pkg::ST_DN: begin
        if (stat_i.l_in) cmd_o.op = ihmt_pkg::OP_RD_LEFT;
      end
      ihmt_pkg::ST_DN_L: cmd_o.op = ihmt_pkg::OP_LATCH_LEFT;
      ihmt_pkg::ST_DN_R: begin
        if (!stat_i.best_is_cur) cmd_o.op = ihmt_pkg::OP_MOVE_CHILD;
      end
      ihmt_pkg::ST_PLACE:    cmd_o.op = ihmt_pkg::OP_PLACE;
      ihmt_pkg::ST_TICK_RD:  cmd_o.op = ihmt_pkg::OP_RD_ROOT;
      ihmt_pkg::ST_TICK_TEST: begin
        if (stat_i.root_due) cmd_o.op = ihmt_pkg::OP_REMOVE;
      end
      ihmt_pkg::ST_FIN_RD:   cmd_o.op = ihmt_pkg::OP_RD_ROOT;
      ihmt_pkg::ST_FIN_DIFF: cmd_o.op = ihmt_pkg::OP_CALC_DIFF;
      ihmt_pkg::ST_FIN_NM:   cmd_o.op = ihmt_pkg::OP_CALC_NM;
      ihmt_pkg::ST_EMIT_RD:  cmd_o.op = ihmt_pkg::OP_RD_POP;
      ihmt_pkg::ST_EMIT_WR: begin
        if (stat_i.out_free) cmd_o.op = ihmt_pkg::OP_EMIT;
      end
      default: cmd_o.op = ihmt_pkg::OP_NONE;
    endcase
  end

endmodule

[hw/rtl/ihmt_datapath.sv]
// Heap, position and pop-buffer memories, the sift registers and the result
// register of the timer queue. Depends on ihmt_pkg; driven by ihmt_ctrl.
module ihmt_datapath #(
  parameter int unsigned HEAP_CAPACITY = 32,
  parameter int unsigned ID_COUNT      = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ihmt_pkg::dp_cmd_t         cmd_i,
  output ihmt_pkg::dp_stat_t        stat_o,
  input  logic [1:0]                in_kind_i,
  input  logic [7:0]                in_id_i,
  input  logic [15:0]               in_tmo_i,
  input  logic [31:0]               in_now_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      out_exp_valid_o,
  output logic [7:0]                out_id_o,
  output logic [ihmt_pkg::NM_W-1:0] out_nm_o,
  output logic [1:0]                out_status_o,
  output logic                      out_last_o
);

  localparam int unsigned PW  = $clog2(HEAP_CAPACITY);
  localparam int unsigned CW  = $clog2(HEAP_CAPACITY + 1);
  localparam int unsigned IDW = $clog2(ID_COUNT);
  localparam int unsigned XW  = PW + 2;

  // heap storage, one write and one read port
  logic [7:0]  heap_id_mem  [HEAP_CAPACITY];
  logic [31:0] heap_exp_mem [HEAP_CAPACITY];
  logic [PW-1:0] pos_mem    [ID_COUNT];
  logic [7:0]  pop_mem      [ihmt_pkg::MAX_RESULTS];

  logic [ID_COUNT-1:0] present_q;

  logic [1:0]    kind_q;
  logic [7:0]    id_q;
  logic [31:0]   now_q, exp_q;
  logic [1:0]    status_q;
  logic [CW-1:0] cnt_q;
  logic [PW-1:0] pos_q;
  logic [7:0]    cur_id_q;
  logic [31:0]   cur_exp_q;
  logic          moved_q;
  logic [7:0]    l_id_q;
  logic [31:0]   l_exp_q;
  logic          l_lt_q;
  logic [ihmt_pkg::NPOP_W-1:0] npop_q, emit_q;
  logic [31:0]   diff_q;
  logic          empty_q, over_q;
  logic [ihmt_pkg::NM_W-1:0] nm_q;
  logic [7:0]    h_rid_q;
  logic [31:0]   h_rexp_q;
  logic [PW-1:0] posrd_q;
  logic [7:0]    popd_q;

  logic          out_valid_q, out_ev_q, out_last_q;
  logic [7:0]    out_id_q;
  logic [ihmt_pkg::NM_W-1:0] out_nm_q;
  logic [1:0]    out_status_q;

  logic [32:0]   exp_sum;
  logic [31:0]   exp_sat;
  logic [XW-1:0] lidx, ridx, cnt_w;
  logic [PW-1:0] parent;
  logic          r_in, r_lt;
  logic [31:0]   best_exp_cur;
  logic [7:0]    best_id;
  logic [31:0]   best_exp;
  logic [PW-1:0] best_pos;
  logic          hrd_en;
  logic [PW-1:0] hrd_addr;
  logic          hwr_en;
  logic [7:0]    hwr_id;
  logic [31:0]   hwr_exp;
  logic          is_tick;
  logic [IDW-1:0] id_idx, rm_idx;
  logic [ihmt_pkg::NPOP_W-1:0] emit_nx;

  assign exp_sum = 33'(in_now_i) + 33'(in_tmo_i);
  assign exp_sat = exp_sum[32] ? '1 : exp_sum[31:0];

  assign lidx     = XW'({pos_q, 1'b1});
  assign ridx     = lidx + XW'(1);
  assign cnt_w    = XW'(cnt_q);
  assign parent   = (pos_q - PW'(1)) >> 1;
  assign r_in     = ridx < cnt_w;
  assign best_exp_cur = l_lt_q ? l_exp_q : cur_exp_q;
  assign r_lt     = r_in && (h_rexp_q < best_exp_cur);
  assign best_id  = r_lt ? h_rid_q : l_id_q;
  assign best_exp = r_lt ? h_rexp_q : l_exp_q;
  assign best_pos = r_lt ? ridx[PW-1:0] : lidx[PW-1:0];
  assign is_tick  = kind_q == ihmt_pkg::KIND_TICK;
  assign id_idx   = IDW'(id_q);
  assign rm_idx   = is_tick ? IDW'(h_rid_q) : id_idx;
  assign emit_nx  = emit_q + ihmt_pkg::NPOP_W'(1);

  // heap read port address
  always_comb begin
    hrd_en   = 1'b1;
    hrd_addr = '0;
    unique case (cmd_i.op)
      ihmt_pkg::OP_RD_TAIL:    hrd_addr = cnt_q[PW-1:0];
      ihmt_pkg::OP_RD_ROOT:    hrd_addr = '0;
      ihmt_pkg::OP_RD_PARENT:  hrd_addr = parent;
      ihmt_pkg::OP_RD_LEFT:    hrd_addr = lidx[PW-1:0];
      ihmt_pkg::OP_LATCH_LEFT: hrd_addr = ridx[PW-1:0];
      default:                 hrd_en   = 1'b0;
    endcase
  end

  // heap write port: always at the hole position
  always_comb begin
    hwr_en  = 1'b1;
    hwr_id  = cur_id_q;
    hwr_exp = cur_exp_q;
    unique case (cmd_i.op)
      ihmt_pkg::OP_MOVE_PARENT: begin
        hwr_id  = h_rid_q;
        hwr_exp = h_rexp_q;
      end
      ihmt_pkg::OP_MOVE_CHILD: begin
        hwr_id  = best_id;
        hwr_exp = best_exp;
      end
      ihmt_pkg::OP_PLACE: ;
      default: hwr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (hwr_en) begin
      heap_id_mem[pos_q]  <= hwr_id;
      heap_exp_mem[pos_q] <= hwr_exp;
      pos_mem[IDW'(hwr_id)] <= pos_q;
    end
    if (hrd_en) begin
      h_rid_q  <= heap_id_mem[hrd_addr];
      h_rexp_q <= heap_exp_mem[hrd_addr];
    end
    if (cmd_i.op == ihmt_pkg::OP_RD_POS) begin
      posrd_q <= pos_mem[id_idx];
    end
    if (cmd_i.op == ihmt_pkg::OP_REMOVE && is_tick) begin
      pop_mem[npop_q[ihmt_pkg::POP_AW-1:0]] <= h_rid_q;
    end
    if (cmd_i.op == ihmt_pkg::OP_RD_POP) begin
      popd_q <= pop_mem[emit_q[ihmt_pkg::POP_AW-1:0]];
    end
  end

  // sift and item registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      ihmt_pkg::OP_LOAD: begin
        kind_q <= in_kind_i;
        id_q   <= in_id_i;
        now_q  <= in_now_i;
        exp_q  <= exp_sat;
      end
      ihmt_pkg::OP_UPD_SET: begin
        pos_q     <= posrd_q;
        cur_id_q  <= id_q;
        cur_exp_q <= exp_q;
        moved_q   <= 1'b0;
      end
      ihmt_pkg::OP_NEW: begin
        pos_q     <= cnt_q[PW-1:0];
        cur_id_q  <= id_q;
        cur_exp_q <= exp_q;
        moved_q   <= 1'b0;
      end
      ihmt_pkg::OP_REMOVE: pos_q <= is_tick ? '0 : posrd_q;
      ihmt_pkg::OP_LD_TAIL: begin
        cur_id_q  <= h_rid_q;
        cur_exp_q <= h_rexp_q;
        moved_q   <= 1'b0;
      end
      ihmt_pkg::OP_MOVE_PARENT: begin
        pos_q   <= parent;
        moved_q <= 1'b1;
      end
      ihmt_pkg::OP_LATCH_LEFT: begin
        l_id_q  <= h_rid_q;
        l_exp_q <= h_rexp_q;
        l_lt_q  <= h_rexp_q < cur_exp_q;
      end
      ihmt_pkg::OP_MOVE_CHILD: pos_q <= best_pos;
      ihmt_pkg::OP_CALC_DIFF: begin
        empty_q <= cnt_q == '0;
        over_q  <= h_rexp_q <= now_q;
        diff_q  <= h_rexp_q - now_q;
      end
      ihmt_pkg::OP_CALC_NM: begin
        priority if (empty_q) nm_q <= '1;
        else if (over_q) nm_q <= '0;
        else if (|diff_q[31:16]) nm_q <= ihmt_pkg::NEXT_MS_MAX;
        else nm_q <= ihmt_pkg::NM_W'(diff_q[15:0]) * ihmt_pkg::NM_W'(ihmt_pkg::MS_PER_S);
      end
      default: ;
    endcase
    if (out_valid_q == 1'b0 || out_ready_i || cmd_i.op == ihmt_pkg::OP_EMIT) begin
      if (cmd_i.op == ihmt_pkg::OP_EMIT) begin
        out_ev_q     <= npop_q != '0;
        out_id_q     <= (npop_q != '0) ? popd_q : 8'd0;
        out_nm_q     <= nm_q;
        out_status_q <= status_q;
        out_last_q   <= stat_o.emit_last;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q   <= '0;
      cnt_q       <= '0;
      npop_q      <= '0;
      emit_q      <= '0;
      status_q    <= ihmt_pkg::STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      unique case (cmd_i.op)
        ihmt_pkg::OP_LOAD: begin
          status_q <= ihmt_pkg::STAT_OK;
          npop_q   <= '0;
          emit_q   <= '0;
        end
        ihmt_pkg::OP_ST_FULL:    status_q <= ihmt_pkg::STAT_FULL;
        ihmt_pkg::OP_ST_UNKNOWN: status_q <= ihmt_pkg::STAT_UNKNOWN;
        ihmt_pkg::OP_NEW: begin
          present_q[id_idx] <= 1'b1;
          cnt_q             <= cnt_q + CW'(1);
        end
        ihmt_pkg::OP_REMOVE: begin
          present_q[rm_idx] <= 1'b0;
          cnt_q             <= cnt_q - CW'(1);
          if (is_tick) npop_q <= npop_q + ihmt_pkg::NPOP_W'(1);
        end
        ihmt_pkg::OP_EMIT: emit_q <= emit_nx;
        default: ;
      endcase
      if (cmd_i.op == ihmt_pkg::OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    stat_o.kind        = ihmt_pkg::kind_e'(kind_q);
    stat_o.id_ok       = 32'(id_q) < ID_COUNT;
    stat_o.present     = stat_o.id_ok && present_q[id_idx];
    stat_o.full        = cnt_q == CW'(HEAP_CAPACITY);
    stat_o.pos_zero    = pos_q == '0;
    stat_o.parent_le   = h_rexp_q <= cur_exp_q;
    stat_o.moved       = moved_q;
    stat_o.l_in        = lidx < cnt_w;
    stat_o.best_is_cur = !l_lt_q && !r_lt;
    stat_o.tail_hit    = XW'(pos_q) == cnt_w;
    stat_o.root_due    = (cnt_q != '0)
                         && (npop_q < ihmt_pkg::NPOP_W'(ihmt_pkg::MAX_RESULTS))
                         && (h_rexp_q <= now_q);
    stat_o.out_free    = !out_valid_q || out_ready_i;
    stat_o.emit_last   = (npop_q == '0) || (emit_nx == npop_q);
  end

  assign out_valid_o     = out_valid_q;
  assign out_exp_valid_o = out_ev_q;
  assign out_id_o        = out_id_q;
  assign out_nm_o        = out_nm_q;
  assign out_status_o    = out_status_q;
  assign out_last_o      = out_last_q;

endmodule

[hw/rtl/indexed_min_heap_timer.sv]
// Indexed binary min-heap timer queue: up to HEAP_CAPACITY timers, each an id
// and an absolute expiry in seconds, with a per-id position table so that a
// timer can be updated or removed by id. Kind 0 adds or updates a timer
// (expiry = now + timeout, saturated), kind 1 removes one, kind 2 ticks and
// pops every timer due at or before now (at most 32 per tick, earliest first,
// one result per popped id), kind 3 does nothing. Every transaction ends with
// a result carrying the milliseconds to the earliest expiry (-1 when empty,
// 0 when overdue, saturated at 65535000) and tlast set. One transaction is
// worked on at a time; the result register lets the next one be accepted
// while a result still waits. The heap memory has a single read port; a
// transaction that moves nothing passes through decode, root read,
// difference, scaling, emit read and emit write, an add or a remove adds the
// sift entry, each level risen or sunk and the placement, and a tick adds the
// root test, tail load, sinking, placement and emission of each popped timer.
// Results leave one at a time, each once the result register is free, and
// the next transaction can be taken in the cycle after the last result is
// registered. No clearing pass is needed after reset: only the presence bits
// and the control registers are cleared, not the memories.
// Depends on ihmt_pkg, ihmt_ctrl and ihmt_datapath.
module indexed_min_heap_timer #(
  parameter int unsigned HEAP_CAPACITY = 32,
  parameter int unsigned ID_COUNT      = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,  // timer_id[7:0], timeout_s[23:8], now_s[55:24]
  input  logic [1:0]  s_axis_tuser_i,  // kind[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // expired_id[7:0], next_timeout_ms[34:8],
                                       // status[36:35], zero[39:37]
  output logic        m_axis_tuser_o,  // expired_valid
  output logic        m_axis_tlast_o   // last result of the transaction
);

  ihmt_pkg::dp_cmd_t  cmd;
  ihmt_pkg::dp_stat_t stat;

  logic                      out_ev;
  logic [7:0]                out_id;
  logic [ihmt_pkg::NM_W-1:0] out_nm;
  logic [1:0]                out_status;

  ihmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ihmt_datapath #(
    .HEAP_CAPACITY (HEAP_CAPACITY),
    .ID_COUNT      (ID_COUNT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .in_kind_i       (s_axis_tuser_i),
    .in_id_i         (s_axis_tdata_i[7:0]),
    .in_tmo_i        (s_axis_tdata_i[23:8]),
    .in_now_i        (s_axis_tdata_i[55:24]),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_exp_valid_o (out_ev),
    .out_id_o        (out_id),
    .out_nm_o        (out_nm),
    .out_status_o    (out_status),
    .out_last_o      (m_axis_tlast_o)
  );

  // pack the result fields, lowest first
  assign m_axis_tdata_o = {3'b000, out_status, out_nm, out_id};
  assign m_axis_tuser_o = out_ev;

endmodule
